// ===== rtl/core/tlvw_pkg.sv =====
// Shared types, codes and helpers for the TLV element stream walker.
// No dependencies; every other file in rtl/core refers to this package.
`timescale 1ns / 1ps

package tlvw_pkg;

	// Most results one input byte can cause
	localparam int MAX_RES = 3;
	// Bundle queue between parser and output serializer
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	// Tag control (top three bits of the control byte)
	localparam logic [2:0] TC_ANON = 3'b000;
	localparam logic [2:0] TC_CTX  = 3'b001;

	// Element types (low five bits of the control byte)
	localparam logic [4:0] T_UINT8  = 5'h04;
	localparam logic [4:0] T_UINT64 = 5'h07;
	localparam logic [4:0] T_STR1   = 5'h10;
	localparam logic [4:0] T_STR2   = 5'h11;
	localparam logic [4:0] T_STRUCT = 5'h15;
	localparam logic [4:0] T_END    = 5'h18;

	typedef enum logic [2:0] {
		PH_CTRL,
		PH_TAG,
		PH_VALUE,
		PH_LEN,
		PH_CONTENT
	} phase_t;

	typedef enum logic [1:0] {
		EV_ELEM,
		EV_CONTENT,
		EV_ERROR,
		EV_END
	} ev_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_TAG,
		ERR_TYPE,
		ERR_TRUNC,
		ERR_DEPTH
	} err_t;

	typedef struct packed {
		ev_t         ev;
		logic        ctx;
		logic [7:0]  tag;
		logic [4:0]  etype;
		logic [63:0] uval;
		logic [15:0] slen;
		logic [7:0]  cb;
		logic [3:0]  depth;
		err_t        err;
	} rec_t;

	// All results of one byte, in order; cnt of them are valid
	typedef struct packed {
		rec_t [MAX_RES-1:0] rec;
		logic [1:0]         cnt;
	} bundle_t;

	function automatic logic type_ok(input logic [4:0] t);
		return t inside {[T_UINT8:T_UINT64], T_STR1, T_STR2, [T_STRUCT:T_END]};
	endfunction

	function automatic rec_t make_rec(
		input ev_t         ev,
		input logic        ctx,
		input logic [7:0]  tag,
		input logic [4:0]  etype,
		input logic [63:0] uval,
		input logic [15:0] slen,
		input logic [7:0]  cb,
		input logic [3:0]  depth,
		input err_t        err
	);
		rec_t r;
		r.ev    = ev;
		r.ctx   = ctx;
		r.tag   = ctx ? tag : 8'h00;
		r.etype = etype;
		r.uval  = uval;
		r.slen  = slen;
		r.cb    = cb;
		r.depth = depth;
		r.err   = err;
		return r;
	endfunction

	// Append one result; drop it once the bundle is full
	function automatic bundle_t add_rec(input bundle_t b, input rec_t r);
		bundle_t o;
		o = b;
		if (b.cnt < 2'(MAX_RES)) begin
			o.rec[b.cnt] = r;
			o.cnt = b.cnt + 2'd1;
		end
		return o;
	endfunction

endpackage

// ===== rtl/core/tlv_element_stream_walker.sv =====
// Top level of the TLV element stream walker: parser, bundle queue and output serializer.
// Depends on tlvw_pkg, tlvw_front, tlvw_queue and tlvw_back.
`timescale 1ns / 1ps

// Usage
//   Input channel s_axis_*: one beat per blob byte, tdata = the byte, tlast on the final
//   byte of the blob. Output channel m_axis_*: one beat per result, tuser = event kind
//   (element complete, string content byte, error, stream end), tdata = the packed
//   result fields, tlast on the last result caused by one input byte.
//   A byte can cause up to three results (content byte, element complete, stream end).
// Data path and throughput
//   The parser decodes a byte in the cycle it is accepted and pushes its result bundle
//   into a four-entry queue; the serializer loads results from the queue head into the
//   output register, so an input beat passes the queue entry and then the output
//   register before m_axis_tvalid rises. Input is taken every cycle while the queue has
//   room; while m_axis_tready is high the serializer drains one result per cycle, so
//   bytes with one result or none run at one byte per cycle and a byte with k results
//   takes k output beats.
// Stall and reset
//   When the receiver holds m_axis_tready low the output register holds its beat, the
//   queue fills, and s_axis_tready drops once the queue is full. An asynchronous reset
//   clears the parse state, empties the queue and drops m_axis_tvalid; the block is
//   ready for a new blob once reset is released.

module tlv_element_stream_walker #(
	parameter int MAX_DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [0] tag_is_context, [8:1] tag_number, [13:9] element_type, [77:14] uint_value,
	// [93:78] string_length, [101:94] content_byte, [105:102] nesting_depth,
	// [108:106] error_code, [111:109] zero
	output logic [111:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser,   // [1:0] event_res
	output logic         m_axis_tlast    // last_result
);

	tlvw_pkg::bundle_t new_bnd;
	tlvw_pkg::bundle_t head_bnd;
	tlvw_pkg::rec_t    out_rec;
	logic              take;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;

	// Accept a byte whenever the queue can hold its bundle
	assign s_axis_tready = !q_full;
	assign take          = s_axis_tvalid && s_axis_tready;

	tlvw_front #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.data_byte(s_axis_tdata),
		.last_byte(s_axis_tlast),
		.push     (push),
		.bnd      (new_bnd)
	);

	tlvw_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (new_bnd),
		.pop   (pop),
		.dout  (head_bnd),
		.full  (q_full),
		.empty (q_empty)
	);

	tlvw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head_bnd),
		.empty    (q_empty),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_rec  (out_rec),
		.out_last (m_axis_tlast)
	);

	// Pack result fields, first field in the lowest bits
	assign m_axis_tuser = out_rec.ev;
	assign m_axis_tdata = {3'b000, out_rec.err, out_rec.depth, out_rec.cb, out_rec.slen,
		out_rec.uval, out_rec.etype, out_rec.tag, out_rec.ctx};

`ifndef SYNTHESIS
	// stream end closes the results of its byte
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_rec.ev == tlvw_pkg::EV_END |-> m_axis_tlast)
		else $error("stream end beat without tlast");

	// content bytes only come from strings with a nonzero length
	a_content_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_rec.ev == tlvw_pkg::EV_CONTENT |-> out_rec.slen != 16'd0)
		else $error("content beat with zero string length");

	// an error beat always carries a code
	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_rec.ev == tlvw_pkg::EV_ERROR |-> out_rec.err != tlvw_pkg::ERR_NONE)
		else $error("error beat without error code");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_rec.depth <= 4'(MAX_DEPTH))
		else $error("nesting depth beyond bound");

	// back-pressure on the input only while the output holds a beat
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with idle output");
`endif

endmodule

// ===== rtl/core/tlvw_front.sv =====
// Parser front end: decodes one byte per accepted beat and builds its result bundle.
// Depends on tlvw_pkg.
`timescale 1ns / 1ps

module tlvw_front #(
	parameter int MAX_DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output logic             push,
	output tlvw_pkg::bundle_t bnd
);

	tlvw_pkg::phase_t phase_q, ph_d;
	logic [4:0]  type_q, type_d;
	logic        ctx_q, ctx_d;
	logic [7:0]  tag_q, tag_d;
	logic [15:0] rem_q, rem_d;
	logic [63:0] vacc_q, vacc_d;
	logic [15:0] lacc_q, lacc_d;
	logic [3:0]  depth_q, depth_d;
	logic        errl_q, errl_d;
	logic        start_body;
	logic [2:0]  tc;
	logic [3:0]  tot;
	logic [2:0]  idx;

	always_comb begin
		ph_d       = phase_q;
		type_d     = type_q;
		ctx_d      = ctx_q;
		tag_d      = tag_q;
		rem_d      = rem_q;
		vacc_d     = vacc_q;
		lacc_d     = lacc_q;
		depth_d    = depth_q;
		errl_d     = errl_q;
		bnd        = '0;
		start_body = 1'b0;
		tc         = data_byte[7:5];
		tot        = 4'd1 << type_q[1:0];
		idx        = 3'(tot - rem_q[3:0]);

		if (!errl_q) begin
			case (phase_q)
				tlvw_pkg::PH_TAG: begin
					tag_d      = data_byte;
					start_body = 1'b1;
				end
				tlvw_pkg::PH_VALUE: begin
					vacc_d = vacc_q | (64'(data_byte) << {idx, 3'b000});
					rem_d  = rem_q - 16'd1;
					if (rem_d == 16'd0) begin
						ph_d = tlvw_pkg::PH_CTRL;
						bnd  = tlvw_pkg::add_rec(bnd, tlvw_pkg::make_rec(tlvw_pkg::EV_ELEM,
							ctx_d, tag_d, type_d, vacc_d, 16'd0, 8'd0, depth_d,
							tlvw_pkg::ERR_NONE));
					end
				end
				tlvw_pkg::PH_LEN: begin
					// second length byte of a two-byte length is the high byte
					if (type_q == tlvw_pkg::T_STR2 && rem_q[0]) begin
						lacc_d = lacc_q | {data_byte, 8'h00};
					end else begin
						lacc_d = lacc_q | {8'h00, data_byte};
					end
					rem_d = rem_q - 16'd1;
					if (rem_d == 16'd0) begin
						if (lacc_d == 16'd0) begin
							ph_d = tlvw_pkg::PH_CTRL;
							bnd  = tlvw_pkg::add_rec(bnd, tlvw_pkg::make_rec(
								tlvw_pkg::EV_ELEM, ctx_d, tag_d, type_d, 64'd0, 16'd0,
								8'd0, depth_d, tlvw_pkg::ERR_NONE));
						end else begin
							rem_d = lacc_d;
							ph_d  = tlvw_pkg::PH_CONTENT;
						end
					end
				end
				tlvw_pkg::PH_CONTENT: begin
					bnd   = tlvw_pkg::add_rec(bnd, tlvw_pkg::make_rec(tlvw_pkg::EV_CONTENT,
						ctx_d, tag_d, type_d, 64'd0, lacc_q, data_byte, depth_d,
						tlvw_pkg::ERR_NONE));
					rem_d = rem_q - 16'd1;
					if (rem_d == 16'd0) begin
						ph_d = tlvw_pkg::PH_CTRL;
						bnd  = tlvw_pkg::add_rec(bnd, tlvw_pkg::make_rec(tlvw_pkg::EV_ELEM,
							ctx_d, tag_d, type_d, 64'd0, lacc_q, 8'd0, depth_d,
							tlvw_pkg::ERR_NONE));
					end
				end
				default: begin
					type_d = data_byte[4:0];
					ctx_d  = (tc == tlvw_pkg::TC_CTX);
					tag_d  = 8'h00;
					if (tc != tlvw_pkg::TC_ANON && tc != tlvw_pkg::TC_CTX) begin
						ctx_d  = 1'b0;
						bnd    = tlvw_pkg::add_rec(bnd, tlvw_pkg::make_rec(
							tlvw_pkg::EV_ERROR, ctx_d, tag_d, type_d, 64'd0, 16'd0, 8'd0,
							depth_d, tlvw_pkg::ERR_TAG));
						errl_d = 1'b1;
						ph_d   = tlvw_pkg::PH_CTRL;
					end else if (!tlvw_pkg::type_ok(type_d)) begin
						bnd    = tlvw_pkg::add_rec(bnd, tlvw_pkg::make_rec(
							tlvw_pkg::EV_ERROR, ctx_d, tag_d, type_d, 64'd0, 16'd0, 8'd0,
							depth_d, tlvw_pkg::ERR_TYPE));
						errl_d = 1'b1;
						ph_d   = tlvw_pkg::PH_CTRL;
					end else if (ctx_d) begin
						ph_d = tlvw_pkg::PH_TAG;
					end else begin
						start_body = 1'b1;
					end
				end
			endcase

			if (start_body) begin
				vacc_d = 64'd0;
				lacc_d = 16'd0;
				if (type_d inside {[tlvw_pkg::T_UINT8:tlvw_pkg::T_UINT64]}) begin
					rem_d = 16'd1 << type_d[1:0];
					ph_d  = tlvw_pkg::PH_VALUE;
				end else if (type_d == tlvw_pkg::T_STR1 || type_d == tlvw_pkg::T_STR2) begin
					rem_d = (type_d == tlvw_pkg::T_STR1) ? 16'd1 : 16'd2;
					ph_d  = tlvw_pkg::PH_LEN;
				end else if (type_d == tlvw_pkg::T_END) begin
					if (depth_d == 4'd0) begin
						bnd    = tlvw_pkg::add_rec(bnd, tlvw_pkg::make_rec(
							tlvw_pkg::EV_ERROR, ctx_d, tag_d, type_d, 64'd0, 16'd0, 8'd0,
							depth_d, tlvw_pkg::ERR_TRUNC));
						errl_d = 1'b1;
						ph_d   = tlvw_pkg::PH_CTRL;
					end else begin
						depth_d = depth_d - 4'd1;
						ph_d    = tlvw_pkg::PH_CTRL;
						bnd     = tlvw_pkg::add_rec(bnd, tlvw_pkg::make_rec(
							tlvw_pkg::EV_ELEM, ctx_d, tag_d, type_d, 64'd0, 16'd0, 8'd0,
							depth_d, tlvw_pkg::ERR_NONE));
					end
				end else begin
					if (depth_d >= 4'(MAX_DEPTH)) begin
						bnd    = tlvw_pkg::add_rec(bnd, tlvw_pkg::make_rec(
							tlvw_pkg::EV_ERROR, ctx_d, tag_d, type_d, 64'd0, 16'd0, 8'd0,
							depth_d, tlvw_pkg::ERR_DEPTH));
						errl_d = 1'b1;
						ph_d   = tlvw_pkg::PH_CTRL;
					end else begin
						depth_d = depth_d + 4'd1;
						ph_d    = tlvw_pkg::PH_CTRL;
						bnd     = tlvw_pkg::add_rec(bnd, tlvw_pkg::make_rec(
							tlvw_pkg::EV_ELEM, ctx_d, tag_d, type_d, 64'd0, 16'd0, 8'd0,
							depth_d, tlvw_pkg::ERR_NONE));
					end
				end
			end

			// blob ends inside an element
			if (last_byte && !errl_d && ph_d != tlvw_pkg::PH_CTRL) begin
				bnd    = tlvw_pkg::add_rec(bnd, tlvw_pkg::make_rec(tlvw_pkg::EV_ERROR,
					ctx_d, tag_d, type_d, 64'd0, 16'd0, 8'd0, depth_d,
					tlvw_pkg::ERR_TRUNC));
				errl_d = 1'b1;
				ph_d   = tlvw_pkg::PH_CTRL;
			end
		end

		if (last_byte) begin
			bnd     = tlvw_pkg::add_rec(bnd, tlvw_pkg::make_rec(tlvw_pkg::EV_END, 1'b0,
				8'h00, 5'd0, 64'd0, 16'd0, 8'd0, depth_d,
				(depth_d != 4'd0) ? tlvw_pkg::ERR_TRUNC : tlvw_pkg::ERR_NONE));
			ph_d    = tlvw_pkg::PH_CTRL;
			type_d  = 5'd0;
			ctx_d   = 1'b0;
			tag_d   = 8'h00;
			rem_d   = 16'd0;
			vacc_d  = 64'd0;
			lacc_d  = 16'd0;
			depth_d = 4'd0;
			errl_d  = 1'b0;
		end
	end

	assign push = take && (bnd.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tlvw_pkg::PH_CTRL;
			type_q  <= '0;
			ctx_q   <= 1'b0;
			tag_q   <= '0;
			rem_q   <= '0;
			vacc_q  <= '0;
			lacc_q  <= '0;
			depth_q <= '0;
			errl_q  <= 1'b0;
		end else if (take) begin
			phase_q <= ph_d;
			type_q  <= type_d;
			ctx_q   <= ctx_d;
			tag_q   <= tag_d;
			rem_q   <= rem_d;
			vacc_q  <= vacc_d;
			lacc_q  <= lacc_d;
			depth_q <= depth_d;
			errl_q  <= errl_d;
		end
	end

endmodule

// ===== rtl/core/tlvw_queue.sv =====
// Short FIFO of result bundles between the parser and the output serializer.
// Depends on tlvw_pkg.
`timescale 1ns / 1ps

module tlvw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tlvw_pkg::bundle_t din,
	input  logic              pop,
	output tlvw_pkg::bundle_t dout,
	output logic              full,
	output logic              empty
);

	tlvw_pkg::bundle_t mem_q [tlvw_pkg::Q_DEPTH];
	logic [tlvw_pkg::Q_PTR_W-1:0] wr_q, rd_q;
	logic [tlvw_pkg::Q_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (tlvw_pkg::Q_PTR_W + 1)'(tlvw_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + (tlvw_pkg::Q_PTR_W)'(1);
			end
			if (pop) begin
				rd_q <= rd_q + (tlvw_pkg::Q_PTR_W)'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (tlvw_pkg::Q_PTR_W + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (tlvw_pkg::Q_PTR_W + 1)'(1);
			end
		end
	end

endmodule

// ===== rtl/core/tlvw_back.sv =====
// Output serializer: walks each queued bundle one result per beat into the output register.
// Depends on tlvw_pkg.
`timescale 1ns / 1ps

module tlvw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tlvw_pkg::bundle_t head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output tlvw_pkg::rec_t    out_rec,
	output logic              out_last
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic       load;
	logic       at_end;

	assign load      = !empty && (!valid_q || out_ready);
	assign at_end    = (idx_q == head.cnt - 2'd1);
	assign pop       = load && at_end;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_rec  <= head.rec[idx_q];
			out_last <= at_end;
		end
	end

endmodule
